// ===== rtl/brr_pkg.sv =====
// shared types and constants for the brr adpcm block decoder
// no dependencies
package brr_pkg;

  localparam int SampleW = 16;
  localparam int AccW    = 20;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  localparam logic [3:0] RangeLimit = 4'd12;
  localparam logic signed [AccW-1:0] RangeOverflow = -20'sd4096;
  localparam logic signed [AccW-1:0] ClampHigh = 20'sd32767;
  localparam logic signed [AccW-1:0] ClampLow  = -20'sd32768;
  localparam logic signed [AccW-1:0] CoefThree    = 20'sd3;
  localparam logic signed [AccW-1:0] CoefThirteen = 20'sd13;

  localparam logic [2:0] LastDataByte = 3'd7;

  typedef enum logic [1:0] {
    FILT_NONE = 2'd0,
    FILT_ONE  = 2'd1,
    FILT_TWO  = 2'd2,
    FILT_THREE = 2'd3
  } filter_t;

  typedef struct packed {
    logic [3:0] range_shift;
    filter_t    filter_mode;
    logic [1:0] flag_bits;
  } brr_hdr_t;

endpackage

// ===== rtl/brr_in_if.sv =====
// input channel of the brr decoder: one header or data byte per item
// depends on nothing
interface brr_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         block_byte;
  logic signed [15:0] start_newest;
  logic signed [15:0] start_older;

  modport source (output valid, command, block_byte, start_newest, start_older,
                  input ready);
  modport sink (input valid, command, block_byte, start_newest, start_older,
                output ready);
endinterface

// ===== rtl/brr_out_if.sv =====
// output channel of the brr decoder: one decoded sample per item
// depends on nothing
interface brr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_of_block;
  logic [1:0]         end_loop_flags;

  modport source (output valid, sample, last_of_block, end_loop_flags, input ready);
  modport sink (input valid, sample, last_of_block, end_loop_flags, output ready);
endinterface

// ===== rtl/brr_adpcm_block_decoder.sv =====
// brr adpcm block decoder top: input register, header and history state,
// one shared sample filter and an output register; depends on brr_pkg,
// brr_in_if, brr_out_if and brr_filter
// a data byte is held for its two samples, high nibble first, one filter pass per
// sample, each loaded when the output is free; the next byte enters with the second;
// one header byte per cycle; synchronous reset clears the header and history
module brr_adpcm_block_decoder
  import brr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  brr_in_if.sink    block_in,
  brr_out_if.source sample_out
);

  logic               st_valid;
  logic               st_cmd;
  logic [7:0]         st_byte;
  logic signed [15:0] st_newest;
  logic signed [15:0] st_older;
  logic               phase;

  brr_hdr_t           hdr;
  logic signed [15:0] hist_newest;
  logic signed [15:0] hist_older;
  logic [2:0]         data_byte_count;

  logic               out_valid;
  logic signed [15:0] out_sample;
  logic               out_last;
  logic [1:0]         out_flags;

  logic               out_load_ok;
  logic               st_is_hdr;
  logic               fire_sample;
  logic               st_done;
  logic               accept;
  logic [3:0]         nibble;
  logic signed [15:0] new_sample;

  assign out_load_ok = !out_valid || sample_out.ready;
  assign st_is_hdr   = (st_cmd == CMD_HEADER);
  assign fire_sample = st_valid && !st_is_hdr && out_load_ok;
  assign st_done     = st_valid && (st_is_hdr || (phase && out_load_ok));
  assign block_in.ready = !st_valid || st_done;
  assign accept      = block_in.valid && block_in.ready;
  assign nibble      = phase ? st_byte[3:0] : st_byte[7:4];

  brr_filter u_filter (
    .hdr    (hdr),
    .nibble (nibble),
    .newest (hist_newest),
    .older  (hist_older),
    .sample (new_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid        <= 1'b0;
      phase           <= 1'b0;
      out_valid       <= 1'b0;
      hdr             <= '{range_shift: 4'd0, filter_mode: FILT_NONE, flag_bits: 2'd0};
      hist_newest     <= '0;
      hist_older      <= '0;
      data_byte_count <= '0;
    end else begin
      if (accept) begin
        st_valid <= 1'b1;
        phase    <= 1'b0;
      end else begin
        if (st_done) begin
          st_valid <= 1'b0;
        end
        if (fire_sample) begin
          phase <= !phase;
        end
      end
      if (st_valid && st_is_hdr) begin
        hdr.range_shift <= st_byte[7:4];
        hdr.filter_mode <= filter_t'(st_byte[3:2]);
        hdr.flag_bits   <= st_byte[1:0];
        hist_newest     <= st_newest;
        hist_older      <= st_older;
        data_byte_count <= '0;
      end else if (fire_sample) begin
        hist_older  <= hist_newest;
        hist_newest <= new_sample;
        if (phase) begin
          data_byte_count <= data_byte_count + 3'd1;
        end
      end
      if (fire_sample) begin
        out_valid <= 1'b1;
      end else if (sample_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      st_cmd    <= block_in.command;
      st_byte   <= block_in.block_byte;
      st_newest <= block_in.start_newest;
      st_older  <= block_in.start_older;
    end
    if (fire_sample) begin
      out_sample <= new_sample;
      out_last   <= phase && (data_byte_count == LastDataByte);
      out_flags  <= hdr.flag_bits;
    end
  end

  assign sample_out.valid          = out_valid;
  assign sample_out.sample         = out_sample;
  assign sample_out.last_of_block  = out_last;
  assign sample_out.end_loop_flags = out_flags;

endmodule

// ===== rtl/brr_filter.sv =====
// nibble expansion, predictor filter, clamp and doubling for one sample
// depends on brr_pkg
module brr_filter
  import brr_pkg::*;
(
  input  brr_hdr_t           hdr,
  input  logic [3:0]         nibble,
  input  logic signed [15:0] newest,
  input  logic signed [15:0] older,
  output logic signed [15:0] sample
);

  logic signed [3:0]      nib_s;
  logic signed [AccW-1:0] expanded;
  logic signed [AccW-1:0] p1;
  logic signed [AccW-1:0] p2;
  logic signed [AccW-1:0] neg_p1;
  logic signed [AccW-1:0] p1_m3;
  logic signed [AccW-1:0] p1_m13;
  logic signed [AccW-1:0] p2_x3;
  logic signed [AccW-1:0] acc;
  logic signed [SampleW-1:0] clamped;

  assign nib_s = signed'(nibble);
  assign p1 = AccW'(newest);
  assign p2 = AccW'(older) >>> 1;
  assign neg_p1 = -p1;
  assign p1_m3 = -(p1 * CoefThree);
  assign p1_m13 = -(p1 * CoefThirteen);
  assign p2_x3 = p2 * CoefThree;

  always_comb begin
    if (hdr.range_shift <= RangeLimit) begin
      expanded = AccW'(nib_s) <<< hdr.range_shift;
    end else begin
      expanded = nib_s[3] ? RangeOverflow : '0;
    end
    acc = expanded >>> 1;
    case (hdr.filter_mode)
      FILT_NONE: begin
        acc = acc;
      end
      FILT_ONE: begin
        acc = acc + (p1 >>> 1) + (neg_p1 >>> 5);
      end
      FILT_TWO: begin
        acc = acc + p1 - p2 + (p2 >>> 4) + (p1_m3 >>> 6);
      end
      FILT_THREE: begin
        acc = acc + p1 - p2 + (p1_m13 >>> 7) + (p2_x3 >>> 4);
      end
      default: begin
        acc = acc;
      end
    endcase
    if (acc > ClampHigh) begin
      clamped = ClampHigh[SampleW-1:0];
    end else if (acc < ClampLow) begin
      clamped = ClampLow[SampleW-1:0];
    end else begin
      clamped = acc[SampleW-1:0];
    end
    sample = {clamped[SampleW-2:0], 1'b0};
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench for brr_adpcm_block_decoder: directed and random blocks, with a
// sample predictor class that checks every decoded item in order
// depends on brr_pkg, brr_in_if, brr_out_if and the decoder rtl
module tb_top;
  import brr_pkg::*;

  localparam int ItemTarget = 1550;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int ReportLimit = 10;
  localparam int TimeoutTime = 4000000;

  typedef struct {
    logic signed [15:0] sample;
    logic               last_of_block;
    logic [1:0]         end_loop_flags;
  } sample_item_t;

  class brr_sample_predictor;
    logic [3:0]   range_shift;
    filter_t      filter_mode;
    logic [1:0]   flag_bits;
    int           newest;
    int           older;
    logic [2:0]   byte_count;
    sample_item_t expected_samples[$];
    int           mismatches;

    function new();
      range_shift = '0;
      filter_mode = FILT_NONE;
      flag_bits = '0;
      newest = 0;
      older = 0;
      byte_count = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return expected_samples.size();
    endfunction

    function int expand_nibble(logic [3:0] nib);
      int n;
      n = nib;
      if (nib[3]) n -= 16;
      if (range_shift <= RangeLimit) return n * (1 << range_shift);
      return (n < 0) ? -4096 : 0;
    endfunction

    function logic signed [15:0] filter_nibble(logic [3:0] nib);
      int s;
      int p1;
      int p2;
      logic [15:0] w;
      s = expand_nibble(nib) >>> 1;
      p1 = newest;
      p2 = older >>> 1;
      case (filter_mode)
        FILT_NONE: ;
        FILT_ONE: begin
          s += p1 >>> 1;
          s += (-p1) >>> 5;
        end
        FILT_TWO: begin
          s += p1;
          s -= p2;
          s += p2 >>> 4;
          s += (p1 * -3) >>> 6;
        end
        FILT_THREE: begin
          s += p1;
          s -= p2;
          s += (p1 * -13) >>> 7;
          s += (p2 * 3) >>> 4;
        end
      endcase
      if (s > 32767) s = 32767;
      else if (s < -32768) s = -32768;
      w = 16'(s << 1);
      older = newest;
      newest = $signed(w);
      return $signed(w);
    endfunction

    function void note_item(logic cmd, logic [7:0] b, logic signed [15:0] n,
                            logic signed [15:0] o);
      sample_item_t hi;
      sample_item_t lo;
      if (cmd == CMD_HEADER) begin
        range_shift = b[7:4];
        filter_mode = filter_t'(b[3:2]);
        flag_bits = b[1:0];
        newest = n;
        older = o;
        byte_count = '0;
      end else begin
        hi.last_of_block = 1'b0;
        lo.last_of_block = (byte_count == LastDataByte);
        hi.sample = filter_nibble(b[7:4]);
        lo.sample = filter_nibble(b[3:0]);
        hi.end_loop_flags = flag_bits;
        lo.end_loop_flags = flag_bits;
        byte_count = byte_count + 3'd1;
        expected_samples.push_back(hi);
        expected_samples.push_back(lo);
      end
    endfunction

    function void check_sample(logic signed [15:0] s, logic last, logic [1:0] flags);
      sample_item_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected sample %0d last %0b flags %0d", s, last, flags);
        return;
      end
      want = expected_samples.pop_front();
      if (s !== want.sample || last !== want.last_of_block ||
          flags !== want.end_loop_flags) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("sample mismatch: expected %0d/%0b/%0d got %0d/%0b/%0d",
                   want.sample, want.last_of_block, want.end_loop_flags,
                   s, last, flags);
      end
    endfunction
  endclass

  bit   clk;
  logic rst;
  bit   gaps_on;
  bit   src_calm;
  int   hold_requests;
  int   items_sent;

  brr_sample_predictor predictor = new();

  brr_in_if  block_in();
  brr_out_if sample_out();

  brr_adpcm_block_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .block_in  (block_in),
    .sample_out(sample_out)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (block_in.valid && block_in.ready)
        predictor.note_item(block_in.command, block_in.block_byte,
                            block_in.start_newest, block_in.start_older);
      if (sample_out.valid && sample_out.ready)
        predictor.check_sample(sample_out.sample, sample_out.last_of_block,
                               sample_out.end_loop_flags);
    end
  end

  initial begin
    #(TimeoutTime);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall bursts, calm stretches, and a long hold on request
  initial begin
    int stall_left;
    int stretch_left;
    int hold_served;
    bit calm;
    stall_left = 0;
    stretch_left = 0;
    hold_served = 0;
    calm = 1'b0;
    sample_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_served < hold_requests) begin
        hold_served++;
        sample_out.ready = 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
      end else begin
        if (stretch_left == 0) begin
          calm = ($urandom_range(0, 3) == 0);
          stretch_left = $urandom_range(20, 120);
        end
        stretch_left--;
        if (stall_left > 0) begin
          stall_left--;
          sample_out.ready = 1'b0;
        end else if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(0, 5);
          sample_out.ready = 1'b0;
        end else begin
          sample_out.ready = 1'b1;
        end
        @(negedge clk);
      end
    end
  end

  function automatic logic [7:0] header_byte(logic [3:0] r, filter_t f, logic [1:0] fl);
    return {r, f, fl};
  endfunction

  function automatic logic signed [15:0] random_start();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_data();
    logic [7:0] picks[6];
    picks = '{8'h88, 8'h77, 8'h80, 8'h08, 8'hff, 8'h00};
    if ($urandom_range(0, 9) == 0) return picks[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic cmd, logic [7:0] b, logic signed [15:0] n,
                           logic signed [15:0] o);
    if (gaps_on && !src_calm && $urandom_range(0, 5) == 0) begin
      block_in.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    block_in.valid = 1'b1;
    block_in.command = cmd;
    block_in.block_byte = b;
    block_in.start_newest = n;
    block_in.start_older = o;
    @(posedge clk);
    while (!block_in.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_block(logic [7:0] hdr, int data_bytes);
    send_item(CMD_HEADER, hdr, random_start(), random_start());
    repeat (data_bytes) send_item(CMD_DATA, random_data(), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    while (predictor.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    int pick;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst = 1'b1;
    gaps_on = 1'b1;
    src_calm = 1'b0;
    hold_requests = 0;
    items_sent = 0;
    block_in.valid = 1'b0;
    block_in.command = CMD_HEADER;
    block_in.block_byte = '0;
    block_in.start_newest = '0;
    block_in.start_older = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // data ahead of any header, then range and filter extremes
    send_item(CMD_DATA, 8'h80, 16'sh7fff, 16'sh8000);
    send_item(CMD_DATA, 8'h7f, 16'sh8000, 16'sh7fff);
    send_item(CMD_HEADER, header_byte(4'd12, FILT_NONE, 2'd3), 16'sh7fff, 16'sh8000);
    send_item(CMD_DATA, 8'h87, 16'sh0000, 16'sh0000);
    send_item(CMD_DATA, 8'hf0, 16'shffff, 16'shffff);
    send_item(CMD_HEADER, header_byte(4'd13, FILT_ONE, 2'd1), 16'sh8000, 16'sh7fff);
    send_item(CMD_DATA, 8'h88, 16'sh0000, 16'sh0000);
    send_item(CMD_DATA, 8'h7f, 16'sh0000, 16'sh0000);
    send_item(CMD_HEADER, header_byte(4'd15, FILT_TWO, 2'd2), 16'sh7fff, 16'sh8000);
    send_item(CMD_DATA, 8'h8f, 16'sh0000, 16'sh0000);
    send_item(CMD_DATA, 8'h00, 16'sh0000, 16'sh0000);
    send_item(CMD_HEADER, header_byte(4'd0, FILT_THREE, 2'd0), 16'sh7fff, 16'sh7fff);
    send_item(CMD_DATA, 8'h77, 16'sh0000, 16'sh0000);
    send_item(CMD_DATA, 8'h88, 16'sh0000, 16'sh0000);
    // full block plus one extra data byte to wrap the byte count
    send_item(CMD_HEADER, header_byte(4'd12, FILT_THREE, 2'd3), 16'sh8000, 16'sh7fff);
    for (int i = 0; i < 9; i++)
      send_item(CMD_DATA, (i % 2) ? 8'h77 : 8'h88, 16'sh0000, 16'sh0000);

    while (items_sent < ItemTarget) begin
      if (!hold_done && items_sent > ItemTarget * 2 / 5) begin
        hold_requests++;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent > ItemTarget * 3 / 5) begin
        block_in.valid = 1'b0;
        wait_drained();
        drain_done = 1'b1;
      end
      if (items_sent > ItemTarget * 17 / 20) gaps_on = 1'b0;
      src_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        send_block(8'($urandom_range(0, 255)), 8);
      end else if (pick < 19) begin
        send_block(8'($urandom_range(0, 255)), $urandom_range(0, 12));
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(CMD_DATA, random_data(), 16'($urandom), 16'($urandom));
      end
    end

    block_in.valid = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (predictor.mismatches == 0 && predictor.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
